[design/assert_macros.svh]
// Assertion helpers: full checks in simulation, empty bodies in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[design/cbim_pkg.sv]
package cbim_pkg;

    localparam logic [15:0] ADDR_MASK = 16'hF0CF;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PRG    = 2'd1;
    localparam logic [1:0] ACT_CHR    = 2'd2;
    localparam logic [1:0] ACT_MIRROR = 2'd3;

    localparam logic [2:0] PRG_SLOT_LOW  = 3'd4;
    localparam logic [2:0] PRG_SLOT_MID  = 3'd5;
    localparam logic [2:0] PRG_SLOT_SWAP = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_PRG_8000,
        OP_PRG_A000,
        OP_MIRROR,
        OP_SWAP,
        OP_CHR,
        OP_IRQ_LO,
        OP_IRQ_HI,
        OP_IRQ_ACK,
        OP_IRQ_CTRL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [2:0] chr_slot;
        logic       chr_high;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[design/cbim_front.sv]
module cbim_front
    import cbim_pkg::*;
(
    input  logic        req_type,
    input  logic [15:0] addr,
    input  logic [7:0]  data,
    output cmd_t        cmd
);

    logic [15:0] m;
    logic [3:0]  top;
    logic [7:0]  low;
    logic        half_ok;
    logic        odd;
    logic        high;
    logic [1:0]  pair;

    always_comb begin
        m    = addr & ADDR_MASK;
        top  = m[15:12];
        low  = m[7:0];
        pair = 2'(top[1:0] + 2'd1);
        half_ok = 1'b1;
        odd     = 1'b0;
        high    = 1'b0;
        unique case (low)
            8'h00: begin
                odd = 1'b0; high = 1'b0;
            end
            8'h02, 8'h40: begin
                odd = 1'b0; high = 1'b1;
            end
            8'h01, 8'h04, 8'h80: begin
                odd = 1'b1; high = 1'b0;
            end
            8'h03, 8'h06, 8'hC0: begin
                odd = 1'b1; high = 1'b1;
            end
            default: begin
                half_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.op       = OP_NONE;
        cmd.data     = data;
        cmd.chr_slot = {pair, odd};
        cmd.chr_high = high;
        if (req_type) begin
            cmd.op = OP_TICK;
        end else begin
            unique case (m)
                16'h8000: cmd.op = OP_PRG_8000;
                16'hA000: cmd.op = OP_PRG_A000;
                16'h9000: cmd.op = OP_MIRROR;
                16'h9002, 16'h9080: cmd.op = OP_SWAP;
                16'hF000: cmd.op = OP_IRQ_LO;
                16'hF002, 16'hF040: cmd.op = OP_IRQ_HI;
                16'hF003, 16'hF0C0: cmd.op = OP_IRQ_ACK;
                16'hF004, 16'hF080: cmd.op = OP_IRQ_CTRL;
                default: begin
                    if (top >= 4'hB && top <= 4'hE && half_ok) begin
                        cmd.op = OP_CHR;
                    end
                end
            endcase
        end
    end

endmodule

[design/cbim_cmd_fifo.sv]
module cbim_cmd_fifo
    import cbim_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head_cmd,
    output q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/cbim_back.sv]
module cbim_back
    import cbim_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [1:0] out_action,
    output logic [2:0] out_slot,
    output logic [7:0] out_bank,
    output logic [1:0] out_mirror,
    output logic       out_fire
);

    logic [7:0] char_bank_reg [8];
    logic [7:0] char_bank_next;
    logic       swap_mode_reg, swap_mode_next;
    logic [7:0] irq_reload_reg, irq_reload_next;
    logic [7:0] irq_count_reg, irq_count_next;
    logic [1:0] irq_en_reg, irq_en_next;

    logic       valid_reg;
    logic [1:0] action_reg, action_next;
    logic [2:0] slot_reg, slot_next;
    logic [7:0] bank_reg, bank_next;
    logic [1:0] mirror_reg, mirror_next;
    logic       fire_reg, fire_next;

    logic [7:0] cur_chr;
    logic       chr_write;

    assign cmd_pop = cmd_valid && (!valid_reg || out_ready);
    assign cur_chr = char_bank_reg[cmd.chr_slot];

    always_comb begin
        swap_mode_next  = swap_mode_reg;
        irq_reload_next = irq_reload_reg;
        irq_count_next  = irq_count_reg;
        irq_en_next     = irq_en_reg;
        char_bank_next  = cmd.chr_high ? {cmd.data[3:0], cur_chr[3:0]}
                                       : {cur_chr[7:4], cmd.data[3:0]};
        chr_write   = 1'b0;
        action_next = ACT_NONE;
        slot_next   = '0;
        bank_next   = '0;
        mirror_next = '0;
        fire_next   = 1'b0;
        unique case (cmd.op)
            OP_TICK: begin
                if (irq_en_reg[1]) begin
                    if (irq_count_reg == '0) begin
                        irq_count_next = irq_reload_reg;
                        irq_en_next    = {2{irq_en_reg[0]}};
                        fire_next      = 1'b1;
                    end else begin
                        irq_count_next = 8'(irq_count_reg + 1'b1);
                    end
                end
            end
            OP_PRG_8000: begin
                action_next = ACT_PRG;
                slot_next   = swap_mode_reg ? PRG_SLOT_SWAP : PRG_SLOT_LOW;
                bank_next   = cmd.data;
            end
            OP_PRG_A000: begin
                action_next = ACT_PRG;
                slot_next   = PRG_SLOT_MID;
                bank_next   = cmd.data;
            end
            OP_MIRROR: begin
                action_next = ACT_MIRROR;
                mirror_next = cmd.data[1:0];
            end
            OP_SWAP: begin
                swap_mode_next = cmd.data[1];
            end
            OP_CHR: begin
                chr_write   = 1'b1;
                action_next = ACT_CHR;
                slot_next   = cmd.chr_slot;
                bank_next   = char_bank_next;
            end
            OP_IRQ_LO: begin
                irq_reload_next = {irq_reload_reg[7:4], cmd.data[3:0]};
            end
            OP_IRQ_HI: begin
                irq_reload_next = {cmd.data[3:0], irq_reload_reg[3:0]};
            end
            OP_IRQ_ACK: begin
                irq_en_next = {2{irq_en_reg[0]}};
            end
            OP_IRQ_CTRL: begin
                irq_en_next = cmd.data[1:0];
                if (cmd.data[1]) begin
                    irq_count_next = irq_reload_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                char_bank_reg[i] <= 8'(i);
            end
            swap_mode_reg  <= 1'b0;
            irq_reload_reg <= '0;
            irq_count_reg  <= '0;
            irq_en_reg     <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (cmd_pop) begin
                if (chr_write) begin
                    char_bank_reg[cmd.chr_slot] <= char_bank_next;
                end
                swap_mode_reg  <= swap_mode_next;
                irq_reload_reg <= irq_reload_next;
                irq_count_reg  <= irq_count_next;
                irq_en_reg     <= irq_en_next;
                valid_reg      <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            action_reg <= action_next;
            slot_reg   <= slot_next;
            bank_reg   <= bank_next;
            mirror_reg <= mirror_next;
            fire_reg   <= fire_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_slot   = slot_reg;
    assign out_bank   = bank_reg;
    assign out_mirror = mirror_reg;
    assign out_fire   = fire_reg;

endmodule

[design/cartridge_bank_irq_mapper.sv]
// Bank-switch and scanline-IRQ controller for a cartridge.
// Input stream: one item per CPU write or scanline tick. s_tuser is the
// request kind (0 write, 1 tick); s_tdata carries the address and data byte.
// Writes are decoded under the 0xF0CF address mask into program-bank,
// character-bank, mirroring, swap-mode and IRQ latch/enable/acknowledge
// operations; ticks advance the 8-bit IRQ counter.
// Output stream: exactly one item per input item, in order. m_tuser is the
// action code; m_tdata carries slot, bank, mirroring mode and the IRQ flag.
// Each accepted item is decoded into the command queue, then executed into
// the output register, which drives m_tvalid. Throughput: one item per cycle
// while m_tready is high; the back end applies each command against the bank
// and IRQ registers as it pops it from the queue.
// Receiver stall: the output register holds its item, the back end stops
// draining the command queue, and s_tready drops once the queue is full.
// Reset (aresetn low, synchronous): queue and output empty, character
// bank i holds i, swap mode, IRQ latch, counter and enables are zero.
`include "assert_macros.svh"

module cartridge_bank_irq_mapper
    import cbim_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot[2:0], bank[10:3], mirror_mode[12:11],
                                   // irq_fire[13], zero[15:14]
    output logic [1:0]  m_tuser    // action[1:0]
);

    cmd_t      front_cmd;
    cmd_t      head_cmd;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    logic [2:0] out_slot;
    logic [7:0] out_bank;
    logic [1:0] out_mirror;
    logic       out_fire;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    cbim_front u_front (
        .req_type (s_tuser[0]),
        .addr     (s_tdata[15:0]),
        .data     (s_tdata[23:16]),
        .cmd      (front_cmd)
    );

    cbim_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_stat)
    );

    cbim_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (head_cmd),
        .cmd_valid  (!q_stat.empty),
        .cmd_pop    (q_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_action (m_tuser),
        .out_slot   (out_slot),
        .out_bank   (out_bank),
        .out_mirror (out_mirror),
        .out_fire   (out_fire)
    );

    assign m_tdata = {2'b00, out_fire, out_mirror, out_bank, out_slot};

    `ASSERT_IMPLIES(a_full_blocks_input, aclk, aresetn, q_stat.full, !s_tready)
    `ASSERT_IMPLIES(a_no_pop_when_empty, aclk, aresetn, q_pop, !q_stat.empty)
    `ASSERT_NEXT(a_pop_fills_output, aclk, aresetn, q_pop, m_tvalid)

endmodule
